// File: rtl/isd_pkg.sv
// ----------------------------------------------------------------------------
// isd_pkg: shared types, constants and helpers of the idle/sleep detector
// Holds the register map, mode and fault codes, the sequencer states and the
// threshold functions used by the decision step.
// ----------------------------------------------------------------------------
package isd_pkg;

  localparam int FILTER_STAGES = 3;
  localparam int STAGE_CNT_W   = (FILTER_STAGES > 1) ? $clog2(FILTER_STAGES) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_DELAY_S   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEEP_SLEEP_TEMP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_ALPHA       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_ALPHA     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_RANGE    = 3'd5;

  localparam logic [1:0] FAULT_NONE = 2'd0;

  typedef enum logic [1:0] {
    MODE_ACTIVE = 2'd0,
    MODE_SLEEP  = 2'd1,
    MODE_DEEP   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADC_MAG,
    ST_ADC_MUL,
    ST_ADC_ACC,
    ST_PWR_MAG,
    ST_PWR_MUL,
    ST_PWR_ACC,
    ST_DECIDE
  } state_e;

  // Control of the shared filter step unit.
  typedef struct packed {
    logic load;  // capture operands, difference and sign
    logic mul;   // register coefficient times difference
  } lp_ctrl_t;

  // 8 at or below 100 degrees, 20 at or above 450, linear and truncated between.
  function automatic logic [4:0] power_threshold(input logic [8:0] t);
    logic [12:0] n;
    logic [4:0]  thr;
    n   = 13'(t - 9'd100) * 13'd12;
    thr = 5'd8;
    if (t <= 9'd100) begin
      thr = 5'd8;
    end else if (t >= 9'd450) begin
      thr = 5'd20;
    end else begin
      for (int k = 1; k <= 11; k++) begin
        if (n >= 13'(350 * k)) thr = thr + 5'd1;
      end
    end
    return thr;
  endfunction

  // True when the filtered tip temperature falls short of the target by more
  // than the interpolated allowance; all compares are in scaled integers.
  function automatic logic temp_short(input logic [8:0] t, input logic [12:0] fq4);
    logic [21:0] lhs;
    logic [21:0] rhs;
    logic        res;
    if (t <= 9'd100) begin
      res = (22'(t) * 22'd16) > (22'(fq4) + 22'd32);
    end else if (t >= 9'd450) begin
      res = (22'(t) * 22'd16) > (22'(fq4) + 22'd64);
    end else begin
      lhs = 22'(t) * 22'd2784;
      rhs = 22'(fq4) * 22'd175 + 22'd4000;
      res = lhs > rhs;
    end
    return res;
  endfunction

endpackage

// File: rtl/isd_lp_unit.sv
// ----------------------------------------------------------------------------
// isd_lp_unit: shared first-order low-pass step
// Moves x towards goal by alpha*(goal-x) in Q.16, rounded half away from
// zero. Difference and product are registered, so a step runs as load,
// multiply, then the result is read combinationally.
// ----------------------------------------------------------------------------
module isd_lp_unit
  import isd_pkg::*;
(
  input  logic        clk_i,
  input  lp_ctrl_t    ctrl_i,
  input  logic [31:0] x_i,
  input  logic [31:0] goal_i,
  input  logic [15:0] alpha_i,
  output logic [31:0] res_o
);

  logic [31:0] x_q;
  logic        neg_q;
  logic [31:0] mag_q;
  logic [15:0] alpha_q;
  logic [47:0] prod_q;
  logic [48:0] rnd;
  logic [31:0] step;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q     <= x_i;
      alpha_q <= alpha_i;
      neg_q   <= (goal_i < x_i);
      mag_q   <= (goal_i < x_i) ? (x_i - goal_i) : (goal_i - x_i);
    end
    if (ctrl_i.mul) begin
      prod_q <= 48'(alpha_q) * 48'(mag_q);
    end
  end

  // The rounded step never exceeds the difference, so 32 bits hold it.
  assign rnd   = {1'b0, prod_q} + 49'h8000;
  assign step  = rnd[47:16];
  assign res_o = neg_q ? (x_q - step) : (x_q + step);

endmodule

// File: rtl/idle_sleep_detector_top.sv
// ----------------------------------------------------------------------------
// idle_sleep_detector_top: sleep and wake decision for a soldering station
// Smooths the motion-sensor ADC, filters heater power through a cascade of
// low-pass stages while active, and counts still ticks towards sleep.
//
//  Channel   Direction  Payload (lowest bit first)
//  s_axis    in         raw_adc 16, heater_power 10, fault 2,
//                       filtered_temp_q4 13, tip_temp 9, zero pad 6
//  m_axis    out        mode 2, entered_sleep 1, woke_up 1,
//                       filtered_power 10, smoothed_adc 16, zero pad 2
//  cfg       in         write enable, register index 3, data 16
//
// The first item after reset seeds the ADC filter. On a fault tick, in sleep
// or when the power filter is seeded, the power steps are skipped; otherwise
// each of the FILTER_STAGES filter steps uses the shared unit for its load,
// multiply and result steps. Ready is high only while the sequencer is idle;
// the decision step waits while the one-item result register is still occupied.
// Reset clears all filter and mode state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module idle_sleep_detector_top
  import isd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // raw_adc, heater_power, fault, filtered_temp_q4, tip_temp
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // mode, entered_sleep, woke_up, filtered_power, smoothed_adc
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers.
  logic [8:0]  target_temp_q;
  logic [7:0]  sleep_delay_q;
  logic [8:0]  deep_temp_q;
  logic [15:0] adc_alpha_q;
  logic [15:0] power_alpha_q;
  logic [15:0] stable_range_q;

  // Captured input item.
  logic [15:0] raw_q;
  logic [9:0]  pwr_q;
  logic [1:0]  fault_q;
  logic [12:0] fq4_q;
  logic [8:0]  tip_q;

  state_e                 state_q, state_d;
  logic [STAGE_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]            acc_q, acc_d;
  logic                   aseed_q, aseed_d;
  logic [25:0]            stage_q [FILTER_STAGES];
  logic [25:0]            stage_d [FILTER_STAGES];
  logic                   pseed_q, pseed_d;
  logic [15:0]            ref_q, ref_d;
  logic                   rseed_q, rseed_d;
  logic [9:0]             still_q, still_d;
  mode_e                  mode_q, mode_d;
  logic                   ann_q, ann_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]  out_data_q, out_data_d;

  lp_ctrl_t    lp_ctrl;
  logic [31:0] lp_x;
  logic [31:0] lp_goal;
  logic [15:0] lp_alpha;
  logic [31:0] lp_res;

  logic        in_acc;
  logic        adc_done;
  logic [32:0] cur_sum;
  logic [15:0] cur;
  logic [26:0] fpow_sum;
  logic [9:0]  fpow;
  logic [9:0]  still_v;
  logic [15:0] ref_v;
  logic [15:0] diff;
  logic [9:0]  limit;
  logic        entered;
  logic        woke;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_temp_q  <= 9'd300;
      sleep_delay_q  <= 8'd60;
      deep_temp_q    <= 9'd100;
      adc_alpha_q    <= 16'd28830;
      power_alpha_q  <= 16'd21845;
      stable_range_q <= 16'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET_TEMP:     target_temp_q  <= cfg_data_i[8:0];
        CFG_SLEEP_DELAY_S:   sleep_delay_q  <= cfg_data_i[7:0];
        CFG_DEEP_SLEEP_TEMP: deep_temp_q    <= cfg_data_i[8:0];
        CFG_ADC_ALPHA:       adc_alpha_q    <= cfg_data_i;
        CFG_POWER_ALPHA:     power_alpha_q  <= cfg_data_i;
        CFG_STABLE_RANGE:    stable_range_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_q   <= s_axis_tdata_i[15:0];
      pwr_q   <= s_axis_tdata_i[25:16];
      fault_q <= s_axis_tdata_i[27:26];
      fq4_q   <= s_axis_tdata_i[40:28];
      tip_q   <= s_axis_tdata_i[49:41];
    end
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      acc_q       <= '0;
      aseed_q     <= 1'b0;
      pseed_q     <= 1'b0;
      ref_q       <= '0;
      rseed_q     <= 1'b0;
      still_q     <= '0;
      mode_q      <= MODE_ACTIVE;
      ann_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < FILTER_STAGES; i++) stage_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      aseed_q     <= aseed_d;
      pseed_q     <= pseed_d;
      ref_q       <= ref_d;
      rseed_q     <= rseed_d;
      still_q     <= still_d;
      mode_q      <= mode_d;
      ann_q       <= ann_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < FILTER_STAGES; i++) stage_q[i] <= stage_d[i];
    end
  end

  isd_lp_unit u_lp (
    .clk_i   (clk_i),
    .ctrl_i  (lp_ctrl),
    .x_i     (lp_x),
    .goal_i  (lp_goal),
    .alpha_i (lp_alpha),
    .res_o   (lp_res)
  );

  // Rounded filter outputs, read in the decision step.
  assign cur_sum  = {1'b0, acc_q} + 33'h8000;
  assign cur      = cur_sum[32] ? 16'hFFFF : cur_sum[31:16];
  assign fpow_sum = {1'b0, stage_q[FILTER_STAGES-1]} + 27'h8000;
  assign fpow     = fpow_sum[26] ? 10'h3FF : fpow_sum[25:16];
  assign limit    = {sleep_delay_q, 2'b00};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    aseed_d     = aseed_q;
    pseed_d     = pseed_q;
    ref_d       = ref_q;
    rseed_d     = rseed_q;
    still_d     = still_q;
    mode_d      = mode_q;
    ann_d       = ann_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    for (int i = 0; i < FILTER_STAGES; i++) stage_d[i] = stage_q[i];

    lp_ctrl.load = 1'b0;
    lp_ctrl.mul  = 1'b0;
    lp_x         = acc_q;
    lp_goal      = {raw_q, 16'h0000};
    lp_alpha     = adc_alpha_q;

    adc_done = 1'b0;
    still_v  = still_q;
    ref_v    = ref_q;
    diff     = '0;
    entered  = 1'b0;
    woke     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_ADC_MAG;
      end
      ST_ADC_MAG: begin
        if (!aseed_q) begin
          // The first sample ever seen seeds the ADC filter directly.
          acc_d    = {raw_q, 16'h0000};
          aseed_d  = 1'b1;
          adc_done = 1'b1;
        end else begin
          lp_ctrl.load = 1'b1;
          state_d      = ST_ADC_MUL;
        end
      end
      ST_ADC_MUL: begin
        lp_ctrl.mul = 1'b1;
        state_d     = ST_ADC_ACC;
      end
      ST_ADC_ACC: begin
        acc_d    = lp_res;
        adc_done = 1'b1;
      end
      ST_PWR_MAG: begin
        // Stages rotate through the shift line: the stage due next is always
        // at the head, and the stage just updated sits at the tail.
        lp_ctrl.load = 1'b1;
        lp_x         = 32'(stage_q[0]);
        lp_goal      = (cnt_q == '0) ? 32'({pwr_q, 16'h0000})
                                     : 32'(stage_q[FILTER_STAGES-1]);
        lp_alpha     = power_alpha_q;
        state_d      = ST_PWR_MUL;
      end
      ST_PWR_MUL: begin
        lp_ctrl.mul = 1'b1;
        state_d     = ST_PWR_ACC;
      end
      ST_PWR_ACC: begin
        for (int i = 0; i < FILTER_STAGES - 1; i++) stage_d[i] = stage_q[i+1];
        stage_d[FILTER_STAGES-1] = lp_res[25:0];
        if (cnt_q == STAGE_CNT_W'(FILTER_STAGES - 1)) begin
          cnt_d   = '0;
          state_d = ST_DECIDE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_PWR_MAG;
        end
      end
      ST_DECIDE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          if (fault_q == FAULT_NONE) begin
            if (mode_q == MODE_ACTIVE) begin
              if ((fpow > 10'(power_threshold(target_temp_q))) ||
                  temp_short(target_temp_q, fq4_q)) begin
                still_v = '0;
              end
            end
            ref_v = rseed_q ? ref_q : cur;
            diff  = (cur >= ref_v) ? (cur - ref_v) : (ref_v - cur);
            if (diff <= stable_range_q) begin
              if (still_v < limit) still_v = still_v + 10'd1;
              if (still_v >= limit) begin
                if (!ann_q) begin
                  mode_d  = MODE_SLEEP;
                  ann_d   = 1'b1;
                  entered = 1'b1;
                end
                if (tip_q < deep_temp_q) mode_d = MODE_DEEP;
              end
            end else begin
              still_v = '0;
              if (ann_q) begin
                ann_d  = 1'b0;
                mode_d = MODE_ACTIVE;
                woke   = 1'b1;
              end
              ref_v = cur;
            end
            still_d = still_v;
            ref_d   = ref_v;
            rseed_d = 1'b1;
          end else begin
            still_d = '0;
          end
          out_valid_d = 1'b1;
          out_data_d  = {2'b00, cur, fpow, woke, entered, mode_d};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // After the ADC update the power filter runs only while active and
    // fault-free; a first power sample fills every stage at once.
    if (adc_done) begin
      if ((fault_q != FAULT_NONE) || (mode_q != MODE_ACTIVE)) begin
        state_d = ST_DECIDE;
      end else if (!pseed_q) begin
        for (int i = 0; i < FILTER_STAGES; i++) stage_d[i] = {pwr_q, 16'h0000};
        pseed_d = 1'b1;
        state_d = ST_DECIDE;
      end else begin
        cnt_d   = '0;
        state_d = ST_PWR_MAG;
      end
    end
  end

  // Sleep modes and the announcement flag move together.
  a_mode_ann: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_ACTIVE) == !ann_q)
    else $error("mode and sleep announcement disagree");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_ADC_MAG))
    else $error("accepted item did not start the ADC step");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[2] && m_axis_tdata_o[3]))
    else $error("entered_sleep and woke_up both set");

  a_woke_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[3]) |-> (m_axis_tdata_o[1:0] == MODE_ACTIVE))
    else $error("woke_up reported outside active mode");

  a_entered_sleep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[2]) |-> (m_axis_tdata_o[1:0] != MODE_ACTIVE))
    else $error("entered_sleep reported in active mode");

endmodule

// File: tb/sv/isd_sleep_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isd_sleep_checker: result checker for the idle/sleep detector
// Watches the input, result and register write channels. Each accepted item
// is run through a cycle-free model of the sleep decision, and the result is
// queued. Each accepted result is compared field by field with the oldest
// queued one. The failure count and the number of results still owed go
// back to the testbench top.
// ----------------------------------------------------------------------------
module isd_sleep_checker
  import isd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  // raw_adc, heater_power, fault, filtered_temp_q4, tip_temp
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  // mode, entered_sleep, woke_up, filtered_power, smoothed_adc
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [5:0]  pad;
    logic [8:0]  tip_temp;
    logic [12:0] filtered_temp_q4;
    logic [1:0]  fault;
    logic [9:0]  heater_power;
    logic [15:0] raw_adc;
  } tick_in_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic [15:0] smoothed_adc;
    logic [9:0]  filtered_power;
    logic        woke_up;
    logic        entered_sleep;
    logic [1:0]  mode;
  } tick_out_t;

  // Register copies.
  logic [8:0]  target_temp;
  logic [7:0]  sleep_delay_s;
  logic [8:0]  deep_sleep_temp;
  logic [15:0] adc_alpha;
  logic [15:0] power_alpha;
  logic [15:0] stable_range;

  // Decision state, filters in Q.16.
  logic [31:0] adc_acc;
  logic        adc_seeded;
  logic [31:0] pwr_stage [FILTER_STAGES];
  logic        pwr_seeded;
  logic [15:0] ref_adc;
  logic        ref_seeded;
  int unsigned still_ticks;
  mode_e       sleep_mode;
  logic        sleep_announced;

  tick_out_t   expected_ticks [$];

  // Moves x towards goal by alpha times the distance, rounded half away from zero.
  function automatic logic [31:0] lp_move(input logic [31:0] x, input logic [31:0] goal,
                                          input logic [15:0] alpha);
    logic [63:0] delta;
    if (goal >= x) begin
      delta = (64'(alpha) * 64'(goal - x) + 64'h8000) >> 16;
      return x + delta[31:0];
    end
    delta = (64'(alpha) * 64'(x - goal) + 64'h8000) >> 16;
    return x - delta[31:0];
  endfunction

  function automatic logic [16:0] q16_round(input logic [31:0] x);
    return 17'((33'(x) + 33'h8000) >> 16);
  endfunction

  function automatic int unsigned power_limit();
    if (target_temp <= 9'd100) return 8;
    if (target_temp >= 9'd450) return 20;
    return 8 + ((int'(target_temp) - 100) * 12) / 350;
  endfunction

  // Shortfall of the filtered temperature below target, in scaled integers.
  function automatic logic temp_shortfall(input logic [12:0] fq4);
    longint t;
    longint f;
    t = longint'(target_temp);
    f = longint'(fq4);
    if (target_temp <= 9'd100) return (16 * t - f) > 32;
    if (target_temp >= 9'd450) return (16 * t - f) > 64;
    return (2800 * t - 175 * f) > (5600 + 16 * (t - 100));
  endfunction

  function automatic tick_out_t predict_tick(input tick_in_t tk);
    tick_out_t   res;
    logic [31:0] goal;
    logic [16:0] cur;
    logic [16:0] fpow;
    logic [15:0] diff;
    int unsigned limit;
    res  = '0;
    goal = {tk.raw_adc, 16'h0000};
    if (!adc_seeded) begin
      adc_acc    = goal;
      adc_seeded = 1'b1;
    end else begin
      adc_acc = lp_move(adc_acc, goal, adc_alpha);
    end
    cur = q16_round(adc_acc);
    if (cur > 17'hFFFF) cur = 17'hFFFF;

    if (tk.fault != FAULT_NONE) begin
      still_ticks = 0;
    end else begin
      if (sleep_mode == MODE_ACTIVE) begin
        goal = {6'b0, tk.heater_power, 16'h0000};
        if (!pwr_seeded) begin
          for (int k = 0; k < FILTER_STAGES; k++) pwr_stage[k] = goal;
          pwr_seeded = 1'b1;
        end
        pwr_stage[0] = lp_move(pwr_stage[0], goal, power_alpha);
        for (int k = 1; k < FILTER_STAGES; k++) begin
          pwr_stage[k] = lp_move(pwr_stage[k], pwr_stage[k-1], power_alpha);
        end
        // Both clears come before the stillness test, so a still tick counts one.
        if (q16_round(pwr_stage[FILTER_STAGES-1]) > power_limit()) still_ticks = 0;
        if (temp_shortfall(tk.filtered_temp_q4)) still_ticks = 0;
      end
      if (!ref_seeded) begin
        ref_adc    = cur[15:0];
        ref_seeded = 1'b1;
      end
      diff = (cur[15:0] >= ref_adc) ? cur[15:0] - ref_adc : ref_adc - cur[15:0];
      if (diff <= stable_range) begin
        limit = int'(sleep_delay_s) * 4;
        if (still_ticks < limit) still_ticks++;
        if (still_ticks >= limit) begin
          if (!sleep_announced) begin
            sleep_mode        = MODE_SLEEP;
            sleep_announced   = 1'b1;
            res.entered_sleep = 1'b1;
          end
          if (tk.tip_temp < deep_sleep_temp) sleep_mode = MODE_DEEP;
        end
      end else begin
        still_ticks = 0;
        if (sleep_announced) begin
          sleep_announced = 1'b0;
          sleep_mode      = MODE_ACTIVE;
          res.woke_up     = 1'b1;
        end
        ref_adc = cur[15:0];
      end
    end

    fpow = q16_round(pwr_stage[FILTER_STAGES-1]);
    if (fpow > 17'h3FF) fpow = 17'h3FF;
    res.mode           = sleep_mode;
    res.filtered_power = fpow[9:0];
    res.smoothed_adc   = cur[15:0];
    return res;
  endfunction

  tick_out_t got;
  tick_out_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_temp     = 9'd300;
      sleep_delay_s   = 8'd60;
      deep_sleep_temp = 9'd100;
      adc_alpha       = 16'd28830;
      power_alpha     = 16'd21845;
      stable_range    = 16'd1024;
      adc_acc         = '0;
      adc_seeded      = 1'b0;
      for (int k = 0; k < FILTER_STAGES; k++) pwr_stage[k] = '0;
      pwr_seeded      = 1'b0;
      ref_adc         = '0;
      ref_seeded      = 1'b0;
      still_ticks     = 0;
      sleep_mode      = MODE_ACTIVE;
      sleep_announced = 1'b0;
      expected_ticks.delete();
      fail_count_o    = 0;
      pending_o       = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TARGET_TEMP:     target_temp     = cfg_data_i[8:0];
          CFG_SLEEP_DELAY_S:   sleep_delay_s   = cfg_data_i[7:0];
          CFG_DEEP_SLEEP_TEMP: deep_sleep_temp = cfg_data_i[8:0];
          CFG_ADC_ALPHA:       adc_alpha       = cfg_data_i;
          CFG_POWER_ALPHA:     power_alpha     = cfg_data_i;
          CFG_STABLE_RANGE:    stable_range    = cfg_data_i;
          default: ;
        endcase
      end

      // A result can never belong to an item taken at the same edge.
      if (m_tvalid_i && m_tready_i) begin
        got = tick_out_t'(m_tdata_i);
        if (expected_ticks.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: result with no item outstanding: mode %0d flags %b%b pwr %0d adc %0d",
                     $time, got.mode, got.entered_sleep, got.woke_up,
                     got.filtered_power, got.smoothed_adc);
          end
          fail_count_o++;
        end else begin
          want = expected_ticks.pop_front();
          if (got.mode !== want.mode || got.entered_sleep !== want.entered_sleep ||
              got.woke_up !== want.woke_up || got.filtered_power !== want.filtered_power ||
              got.smoothed_adc !== want.smoothed_adc) begin
            if (fail_count_o < 10) begin
              $display("%0t: expected mode %0d entered %b woke %b pwr %0d adc %0d", $time,
                       want.mode, want.entered_sleep, want.woke_up,
                       want.filtered_power, want.smoothed_adc);
              $display("%0t:      got mode %0d entered %b woke %b pwr %0d adc %0d", $time,
                       got.mode, got.entered_sleep, got.woke_up,
                       got.filtered_power, got.smoothed_adc);
            end
            fail_count_o++;
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        expected_ticks.push_back(predict_tick(tick_in_t'(s_tdata_i)));
      end
      pending_o = expected_ticks.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the idle/sleep detector
// Drives sensor ticks in random bursts against a result side that stalls in
// changing patterns. A short directed run covers field extremes, faults,
// zero delay, deep sleep and wake-up; random phases with fresh register
// settings follow, mostly still sequences with movement, faults and noise.
// ----------------------------------------------------------------------------
module tb_top;
  import isd_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_TICKS = 1950;

  localparam logic [1:0] FAULT_TIP_OUT = 2'd1;
  localparam logic [1:0] FAULT_SHORT   = 2'd2;
  localparam logic [1:0] FAULT_UNDEF   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int burst_left  = 0;
  int stall_left  = 0;
  int stall_style = 0;
  int random_sent = 0;

  // Settings the stimulus shapes itself around.
  int cur_target = 300;
  int cur_deep   = 100;

  idle_sleep_detector_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  isd_sleep_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The result side switches between always ready, coin flips, ready whenever the
  // stall count is a multiple of four, and long runs of the same level.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(50, 300);
    end else begin
      stall_left--;
    end
    case (stall_style)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 1) == 1);
      2:       m_tready <= (stall_left % 4 == 0);
      default: m_tready <= ($urandom_range(0, 15) == 0) ? ~m_tready : m_tready;
    endcase
  end

  task automatic send_tick(input int raw, input int pwr, input logic [1:0] fault,
                           input int fq4, input int tip);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, tip[8:0], fq4[12:0], fault, pwr[9:0], raw[15:0]};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drains the block so that registers can be written safely.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[15:0];
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic int pick_value(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  task automatic configure_phase();
    int stable;
    int delay;
    cur_target = pick_value(0, 511);
    if ($urandom_range(0, 5) == 0) cur_target = ($urandom_range(0, 1) == 1) ? 100 : 450;
    cur_deep = pick_value(0, 511);
    delay    = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 4);
    case ($urandom_range(0, 7))
      0:       stable = 0;
      1:       stable = 65535;
      default: stable = $urandom_range(300, 4000);
    endcase
    write_reg(CFG_TARGET_TEMP, cur_target);
    write_reg(CFG_SLEEP_DELAY_S, delay);
    write_reg(CFG_DEEP_SLEEP_TEMP, cur_deep);
    write_reg(CFG_ADC_ALPHA, pick_value(0, 65535));
    write_reg(CFG_POWER_ALPHA, pick_value(0, 65535));
    write_reg(CFG_STABLE_RANGE, stable);
  endtask

  // Mostly still sequences near a resting level, with movement, faults and
  // fully random items mixed in.
  task automatic run_phase(input int count);
    int base_adc;
    int kind;
    int raw;
    int pwr;
    int fq4;
    int tip;
    logic [1:0] fault;
    base_adc = $urandom_range(0, 65535);
    for (int n = 0; n < count; n++) begin
      kind  = $urandom_range(0, 99);
      if (kind >= 78 && kind < 83) base_adc = $urandom_range(0, 65535);
      raw   = clamp(base_adc + $urandom_range(0, 600) - 300, 0, 65535);
      pwr   = $urandom_range(0, 24);
      fault = FAULT_NONE;
      fq4   = clamp(cur_target * 16 + $urandom_range(0, 96) - 64, 0, 8191);
      tip   = clamp(cur_deep + $urandom_range(0, 40) - 20, 0, 511);
      if (kind >= 83 && kind < 88) fault = 2'($urandom_range(1, 3));
      if (kind >= 88) begin
        raw   = $urandom_range(0, 65535);
        pwr   = $urandom_range(0, 1023);
        fault = 2'($urandom_range(0, 3));
        fq4   = $urandom_range(0, 8191);
        tip   = $urandom_range(0, 511);
      end
      send_tick(raw, pwr, fault, fq4, tip);
      random_sent++;
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Reset settings: seeding, field extremes and every fault code.
    send_tick(16'h8000, 5, FAULT_NONE, 4800, 200);
    send_tick(16'hFFFF, 1023, FAULT_NONE, 8191, 511);
    send_tick(0, 0, FAULT_NONE, 0, 0);
    send_tick(16'hFFFF, 1023, FAULT_TIP_OUT, 8191, 511);
    send_tick(0, 0, FAULT_SHORT, 0, 0);
    send_tick(16'h1234, 512, FAULT_UNDEF, 4800, 300);
    settle();

    // Zero delay sleeps on the first still tick; a cold tip turns it deep.
    // The target write is masked to nine bits and the spare indexes do nothing.
    write_reg(CFG_TARGET_TEMP, 16'hFFFF);
    cur_target = 511;
    write_reg(CFG_SLEEP_DELAY_S, 0);
    write_reg(CFG_DEEP_SLEEP_TEMP, 200);
    write_reg(CFG_STABLE_RANGE, 65535);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 0);
    send_tick(16'h1234, 0, FAULT_NONE, 8176, 300);
    send_tick(16'h1234, 0, FAULT_NONE, 8176, 50);
    send_tick(16'h1234, 1023, FAULT_NONE, 0, 300);
    send_tick(16'h1234, 0, FAULT_SHORT, 8176, 300);
    settle();

    // With no tolerance any change is movement and wakes the block.
    write_reg(CFG_STABLE_RANGE, 0);
    write_reg(CFG_ADC_ALPHA, 65535);
    send_tick(16'hFFFF, 0, FAULT_NONE, 8176, 300);
    send_tick(16'hFFFF, 1023, FAULT_NONE, 8176, 300);
    send_tick(0, 1023, FAULT_NONE, 8176, 300);
    send_tick(0, 0, FAULT_NONE, 8176, 0);
    settle();

    while (random_sent < RANDOM_TICKS) begin
      configure_phase();
      run_phase($urandom_range(40, 160));
      settle();
    end

    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
